// ===== hw/rtl/spdm_pkg.sv =====
// Shared constants, codes and helper functions for the Speck Davies-Meyer hash unit.
`timescale 1ns / 1ps

package spdm_pkg;

  // Longest message in bytes. Bytes beyond it are dropped.
  localparam int MAX_LEN     = 64;
  localparam int COUNT_W     = $clog2(MAX_LEN + 1);

  localparam int BLOCK_BYTES = 32;
  localparam int FILL_W      = $clog2(BLOCK_BYTES);
  localparam int LEN_POS     = 28;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int ROUNDS      = 34;
  localparam int ROUND_W     = $clog2(ROUNDS);

  localparam int WORD_W      = 64;
  localparam int CFG_IDX_W   = 2;

  // Input command codes.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd2;

  function automatic logic [WORD_W-1:0] rotr8(input logic [WORD_W-1:0] v);
    rotr8 = {v[7:0], v[WORD_W-1:8]};
  endfunction

  function automatic logic [WORD_W-1:0] rotr61(input logic [WORD_W-1:0] v);
    rotr61 = {v[60:0], v[WORD_W-1:61]};
  endfunction

endpackage

// ===== hw/rtl/speck_davies_meyer_string_hash_unit.sv =====
// Top level of the Speck128/256 Davies-Meyer string hash unit.
`timescale 1ns / 1ps

// The unit hashes a byte string into a 128-bit digest. Each input word carries
// in_cmd and in_data_byte: an append command adds one byte to the message, a
// finish command pads the message and yields one output word with the digest.
// A word moves when valid is high and stall is low on that channel.
// An append that does not complete a 32-byte block leaves the unit idle and
// ready for the next byte. The byte that completes a block starts a
// compression: the unit loads the key schedule and the cipher state, then
// runs the Speck rounds one after another on a single shared round datapath,
// and it takes no input until that is done. A finish pads the block and
// compresses it, runs a second compression when the length field spills into
// an extra block, and then loads the output register. in_stall is high
// whenever a compression or a digest hand-off is in flight.
// The digest sits in an output register; a new message may start while it
// waits. If the receiver holds out_stall, the unit finishes its next digest
// and then waits with in_stall high until the register is free.
// Reset clears the configuration registers and the message counters; the
// block buffer needs no clearing since every byte is written before use.
// Configuration writes take effect at the start of the next message.
module speck_davies_meyer_string_hash_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [spdm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spdm_pkg::WORD_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [7:0]                            in_data_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [spdm_pkg::WORD_W-1:0]           out_digest_low,
  output logic [spdm_pkg::WORD_W-1:0]           out_digest_high
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_OUT
  } state_t;

  typedef logic [spdm_pkg::WORD_W-1:0] word_t;

  // Control state.
  state_t                          state_r, state_nxt;
  logic [spdm_pkg::FILL_W-1:0]     fill_r, fill_nxt;
  logic [spdm_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic [spdm_pkg::ROUND_W-1:0]    round_r, round_nxt;
  logic                            final_r, final_nxt;
  logic                            pad_two_r, pad_two_nxt;
  logic                            out_valid_r, out_valid_nxt;
  word_t                           init_low_r, init_low_nxt;
  word_t                           init_high_r, init_high_nxt;
  word_t                           seed_r, seed_nxt;

  // Data path.
  logic [7:0]                      blk_r [spdm_pkg::BLOCK_BYTES];
  logic [7:0]                      blk_nxt [spdm_pkg::BLOCK_BYTES];
  word_t                           chain0_r, chain0_nxt;
  word_t                           chain1_r, chain1_nxt;
  word_t                           x0_r, x0_nxt;
  word_t                           x1_r, x1_nxt;
  word_t                           k_r [4];
  word_t                           k_nxt [4];
  word_t                           dig_low_r, dig_low_nxt;
  word_t                           dig_high_r, dig_high_nxt;

  // One Speck round, shared by every round of every compression.
  word_t                           rx0, rx1, rk0, rk3;
  logic [31:0]                     len_bits;
  logic                            in_acc;
  logic                            room;

  localparam logic [spdm_pkg::COUNT_W-1:0] MAX_CNT = spdm_pkg::COUNT_W'(spdm_pkg::MAX_LEN);
  localparam logic [spdm_pkg::ROUND_W-1:0] LAST_ROUND = spdm_pkg::ROUND_W'(spdm_pkg::ROUNDS - 1);
  localparam logic [spdm_pkg::FILL_W-1:0]  LAST_FILL =
    spdm_pkg::FILL_W'(spdm_pkg::BLOCK_BYTES - 1);
  localparam logic [spdm_pkg::FILL_W-1:0]  SPILL_FILL = spdm_pkg::FILL_W'(spdm_pkg::LEN_POS);

  assign in_stall        = (state_r != S_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign room            = (count_r < MAX_CNT);
  assign out_valid       = out_valid_r;
  assign out_digest_low  = dig_low_r;
  assign out_digest_high = dig_high_r;

  // The length field is the bit count as a little-endian 32-bit word.
  assign len_bits = 32'(count_r) << 3;

  always_comb begin
    rx1 = (spdm_pkg::rotr8(x1_r) + x0_r) ^ k_r[0];
    rx0 = spdm_pkg::rotr61(x0_r) ^ rx1;
    rk3 = (spdm_pkg::rotr8(k_r[1]) + k_r[0]) ^ word_t'(round_r);
    rk0 = spdm_pkg::rotr61(k_r[0]) ^ rk3;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    round_nxt     = round_r;
    final_nxt     = final_r;
    pad_two_nxt   = pad_two_r;
    out_valid_nxt = out_valid_r && out_stall;
    init_low_nxt  = init_low_r;
    init_high_nxt = init_high_r;
    seed_nxt      = seed_r;
    chain0_nxt    = chain0_r;
    chain1_nxt    = chain1_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    dig_low_nxt   = dig_low_r;
    dig_high_nxt  = dig_high_r;
    for (int i = 0; i < spdm_pkg::BLOCK_BYTES; i++) begin
      blk_nxt[i] = blk_r[i];
    end
    for (int w = 0; w < 4; w++) begin
      k_nxt[w] = k_r[w];
    end

    if (cfg_wr_en) begin
      unique case (cfg_index)
        spdm_pkg::CFG_INIT_LOW:  init_low_nxt  = cfg_data;
        spdm_pkg::CFG_INIT_HIGH: init_high_nxt = cfg_data;
        spdm_pkg::CFG_SEED:      seed_nxt      = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // An empty count means a fresh message: reload the chaining value.
          if (count_r == '0) begin
            chain0_nxt = init_low_r ^ seed_r;
            chain1_nxt = init_high_r ^ seed_r;
          end
          if (in_cmd == spdm_pkg::CMD_APPEND) begin
            if (room) begin
              blk_nxt[fill_r] = in_data_byte;
              count_nxt       = count_r + 1'b1;
              fill_nxt        = fill_r + 1'b1;
              final_nxt       = 1'b0;
              if (fill_r == LAST_FILL) begin
                state_nxt = S_LOAD;
              end
            end
          end else begin
            // Pad: 0x80 after the data, zeros, and the length unless it spills.
            for (int i = 0; i < spdm_pkg::BLOCK_BYTES; i++) begin
              if (spdm_pkg::FILL_W'(i) == fill_r) begin
                blk_nxt[i] = spdm_pkg::PAD_BYTE;
              end else if (spdm_pkg::FILL_W'(i) > fill_r) begin
                if (i >= spdm_pkg::LEN_POS && fill_r < SPILL_FILL) begin
                  blk_nxt[i] = len_bits[8*(i-spdm_pkg::LEN_POS) +: 8];
                end else begin
                  blk_nxt[i] = 8'h00;
                end
              end
            end
            final_nxt   = 1'b1;
            pad_two_nxt = (fill_r >= SPILL_FILL);
            state_nxt   = S_LOAD;
          end
        end
      end

      S_LOAD: begin
        for (int w = 0; w < 4; w++) begin
          for (int b = 0; b < 8; b++) begin
            k_nxt[w][8*b +: 8] = blk_r[8*w + b];
          end
        end
        x0_nxt    = chain0_r;
        x1_nxt    = chain1_r;
        round_nxt = '0;
        state_nxt = S_ROUND;
      end

      S_ROUND: begin
        x0_nxt    = rx0;
        x1_nxt    = rx1;
        k_nxt[0]  = rk0;
        k_nxt[1]  = k_r[2];
        k_nxt[2]  = k_r[3];
        k_nxt[3]  = rk3;
        round_nxt = round_r + 1'b1;
        if (round_r == LAST_ROUND) begin
          chain0_nxt = chain0_r ^ rx0;
          chain1_nxt = chain1_r ^ rx1;
          if (!final_r) begin
            state_nxt = S_IDLE;
          end else if (pad_two_r) begin
            // Extra block: all zeros except the length field.
            for (int i = 0; i < spdm_pkg::BLOCK_BYTES; i++) begin
              if (i >= spdm_pkg::LEN_POS) begin
                blk_nxt[i] = len_bits[8*(i-spdm_pkg::LEN_POS) +: 8];
              end else begin
                blk_nxt[i] = 8'h00;
              end
            end
            pad_two_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          dig_low_nxt   = chain0_r;
          dig_high_nxt  = chain1_r;
          out_valid_nxt = 1'b1;
          fill_nxt      = '0;
          count_nxt     = '0;
          final_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      round_r     <= '0;
      final_r     <= 1'b0;
      pad_two_r   <= 1'b0;
      out_valid_r <= 1'b0;
      init_low_r  <= '0;
      init_high_r <= '0;
      seed_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      round_r     <= round_nxt;
      final_r     <= final_nxt;
      pad_two_r   <= pad_two_nxt;
      out_valid_r <= out_valid_nxt;
      init_low_r  <= init_low_nxt;
      init_high_r <= init_high_nxt;
      seed_r      <= seed_nxt;
    end
    chain0_r   <= chain0_nxt;
    chain1_r   <= chain1_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    dig_low_r  <= dig_low_nxt;
    dig_high_r <= dig_high_nxt;
    for (int i = 0; i < spdm_pkg::BLOCK_BYTES; i++) begin
      blk_r[i] <= blk_nxt[i];
    end
    for (int w = 0; w < 4; w++) begin
      k_r[w] <= k_nxt[w];
    end
  end

endmodule

// ===== hw/rtl/spdm_checker.sv =====
// Port-level checker for the hash unit, bound to the top level.
`timescale 1ns / 1ps

module spdm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_cmd,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [spdm_pkg::WORD_W-1:0]    out_digest_low,
  input logic [spdm_pkg::WORD_W-1:0]    out_digest_high
);

  // A held digest stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_low) &&
      $stable(out_digest_high))
    else $error("digest changed or dropped while stalled");

  // A finish runs at least a full compression before more input is taken.
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == spdm_pkg::CMD_FINISH |=> in_stall ##34 in_stall)
    else $error("input taken during finish compression");

  // A new digest only appears after the unit has been busy.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("digest appeared without a compression");

  // Reset leaves no digest pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind speck_davies_meyer_string_hash_unit spdm_checker u_spdm_checker (.*);

// ===== sim/speck_davies_meyer_string_hash_unit_tb.sv =====
// Self-checking testbench for the Speck128/256 Davies-Meyer string hash unit.
`timescale 1ns / 1ps
module speck_davies_meyer_string_hash_unit_tb;

  // Run control. The settle pause covers the slowest finish: a spilled
  // length field costs two compressions plus the output register load.
  localparam int LIMIT_CYCLES    = 400000;
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_CYCLES     = 600;
  localparam int WORDS_PER_PHASE = 245;

  // Index 3 decodes to no register; writing it must change nothing.
  localparam logic [spdm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } hash_word_t;

  typedef struct packed {
    logic [spdm_pkg::WORD_W-1:0] low;
    logic [spdm_pkg::WORD_W-1:0] high;
  } digest_t;

  // Directed words. Nothing here is obvious by eye since every digest goes
  // through the cipher, so every row is checked against the predictor.
  localparam hash_word_t DIRECTED_WORDS [0:19] = '{
    {spdm_pkg::CMD_FINISH, 8'h00},  // empty message under the reset configuration
    {spdm_pkg::CMD_APPEND, 8'h00},  // a zero byte is data, it does not end the message
    {spdm_pkg::CMD_FINISH, 8'hFF},  // the data byte of a finish is ignored
    {spdm_pkg::CMD_APPEND, 8'hFF},
    {spdm_pkg::CMD_APPEND, 8'h80},  // data byte equal to the pad byte
    {spdm_pkg::CMD_APPEND, 8'h01},
    {spdm_pkg::CMD_FINISH, 8'h5A},
    {spdm_pkg::CMD_APPEND, 8'h61},
    {spdm_pkg::CMD_APPEND, 8'h62},
    {spdm_pkg::CMD_APPEND, 8'h63},
    {spdm_pkg::CMD_FINISH, 8'h00},
    {spdm_pkg::CMD_FINISH, 8'h80},  // back-to-back empty message
    {spdm_pkg::CMD_APPEND, 8'h00},
    {spdm_pkg::CMD_APPEND, 8'h00},
    {spdm_pkg::CMD_APPEND, 8'hFF},
    {spdm_pkg::CMD_APPEND, 8'h7F},
    {spdm_pkg::CMD_APPEND, 8'hFE},
    {spdm_pkg::CMD_FINISH, 8'h01},
    {spdm_pkg::CMD_APPEND, 8'hAA},
    {spdm_pkg::CMD_FINISH, 8'h55}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [spdm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [spdm_pkg::WORD_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_cmd = spdm_pkg::CMD_APPEND;
  logic [7:0]                     in_data_byte = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [spdm_pkg::WORD_W-1:0]    out_digest_low;
  logic [spdm_pkg::WORD_W-1:0]    out_digest_high;

  // Predictor state: our own copy of the registers and the message buffer.
  logic [spdm_pkg::WORD_W-1:0] init_low_reg = '0;
  logic [spdm_pkg::WORD_W-1:0] init_high_reg = '0;
  logic [spdm_pkg::WORD_W-1:0] seed_reg = '0;
  logic [spdm_pkg::WORD_W-1:0] chain_word [2];
  logic [7:0]                  block_buf [spdm_pkg::BLOCK_BYTES];
  int unsigned                 fill_pos = 0;
  int unsigned                 msg_len = 0;

  // Digests predicted for accepted finish words, oldest first.
  digest_t digests_pending [$];
  digest_t oldest_digest;

  int error_count = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  speck_davies_meyer_string_hash_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_low  (out_digest_low),
    .out_digest_high (out_digest_high)
  );

  always #5 clk = ~clk;

  function automatic logic [spdm_pkg::WORD_W-1:0] ror64(
    input logic [spdm_pkg::WORD_W-1:0] v, input int n);
    return (v >> n) | (v << (spdm_pkg::WORD_W - n));
  endfunction

  // One Davies-Meyer compression: the block is the Speck key, the chain is
  // encrypted under it and the ciphertext folds back into the chain.
  function automatic void dm_compress();
    logic [spdm_pkg::WORD_W-1:0] key [4];
    logic [spdm_pkg::WORD_W-1:0] x0, x1, spill;
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 8; b++) begin
        key[w][8*b +: 8] = block_buf[8*w + b];
      end
    end
    x0 = chain_word[0];
    x1 = chain_word[1];
    for (int r = 0; r < spdm_pkg::ROUNDS; r++) begin
      x1     = (ror64(x1, 8) + x0) ^ key[0];
      x0     = ror64(x0, 61) ^ x1;
      spill  = key[3];
      key[3] = (ror64(key[1], 8) + key[0]) ^ spdm_pkg::WORD_W'(r);
      key[0] = ror64(key[0], 61) ^ key[3];
      key[1] = key[2];
      key[2] = spill;
    end
    chain_word[0] ^= x0;
    chain_word[1] ^= x1;
  endfunction

  // Advances the predicted hash state by one accepted word. A finish word
  // pads the block, appends the bit length and yields the digest.
  function automatic void hash_step(input logic cmd, input logic [7:0] data,
                                    output bit has_digest, output digest_t digest);
    logic [31:0] bit_len;
    has_digest = 1'b0;
    digest = '0;
    // The chain reloads from the registers at the start of every message.
    if (msg_len == 0) begin
      chain_word[0] = init_low_reg ^ seed_reg;
      chain_word[1] = init_high_reg ^ seed_reg;
    end
    if (cmd == spdm_pkg::CMD_APPEND) begin
      // Bytes past the maximum length are dropped and not counted.
      if (msg_len < spdm_pkg::MAX_LEN) begin
        block_buf[fill_pos % spdm_pkg::BLOCK_BYTES] = data;
        msg_len++;
        fill_pos++;
        if (fill_pos >= spdm_pkg::BLOCK_BYTES) begin
          dm_compress();
          fill_pos = 0;
        end
      end
    end else begin
      fill_pos = fill_pos % spdm_pkg::BLOCK_BYTES;
      for (int i = fill_pos; i < spdm_pkg::BLOCK_BYTES; i++) begin
        block_buf[i] = '0;
      end
      block_buf[fill_pos] = spdm_pkg::PAD_BYTE;
      // No room for the length field after the pad byte: spill to a new block.
      if (fill_pos >= spdm_pkg::LEN_POS) begin
        dm_compress();
        foreach (block_buf[i]) block_buf[i] = '0;
      end
      bit_len = 32'(msg_len * 8);
      for (int i = 0; i < 4; i++) begin
        block_buf[spdm_pkg::LEN_POS + i] = bit_len[8*i +: 8];
      end
      dm_compress();
      digest.low  = chain_word[0];
      digest.high = chain_word[1];
      has_digest  = 1'b1;
      foreach (block_buf[i]) block_buf[i] = '0;
      fill_pos = 0;
      msg_len  = 0;
    end
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Offers one word after a random number of idle cycles and holds it until
  // the unit takes it. in_stall is read right after the edge, so it is the
  // value the unit itself saw at that edge.
  task automatic offer_word(input logic cmd, input logic [7:0] data);
    bit      has_digest;
    digest_t digest;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_step(cmd, data, has_digest, digest);
    if (has_digest) digests_pending.push_back(digest);
    words_sent++;
  endtask

  // Lowers valid and waits for every predicted digest to come out. The loop
  // waits on the clock before it checks, so valid never drops and rises within one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (digests_pending.size() != 0);
  endtask

  task automatic write_config(input logic [spdm_pkg::CFG_IDX_W-1:0] index,
                              input logic [spdm_pkg::WORD_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    unique case (index)
      spdm_pkg::CFG_INIT_LOW:  init_low_reg = value;
      spdm_pkg::CFG_INIT_HIGH: init_high_reg = value;
      spdm_pkg::CFG_SEED:      seed_reg = value;
      default: ;
    endcase
  endtask

  // New settings only go in once the unit is idle. The settle pause covers
  // a compression that an append may still have running.
  task automatic load_settings(input logic [spdm_pkg::WORD_W-1:0] low,
                               input logic [spdm_pkg::WORD_W-1:0] high,
                               input logic [spdm_pkg::WORD_W-1:0] seed);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_config(spdm_pkg::CFG_INIT_LOW, low);
    write_config(spdm_pkg::CFG_INIT_HIGH, high);
    write_config(spdm_pkg::CFG_SEED, seed);
    write_config(CFG_SPARE, {$urandom, $urandom});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      offer_word(spdm_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
    end
    offer_word(spdm_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Mostly short messages; some span a block, some run past the maximum
  // length so the tail gets dropped.
  function automatic int pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 20);
    if (roll < 90) return $urandom_range(21, 40);
    return $urandom_range(41, spdm_pkg::MAX_LEN + 8);
  endfunction

  task automatic run_phase(input int sender_pct, input int receiver_pct,
                           input logic [spdm_pkg::WORD_W-1:0] low,
                           input logic [spdm_pkg::WORD_W-1:0] high,
                           input logic [spdm_pkg::WORD_W-1:0] seed, input bit length_sweep,
                           input int pause_after);
    int target;
    int msg_index;
    load_settings(low, high, seed);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
    target = words_sent + WORDS_PER_PHASE;
    msg_index = 0;
    if (length_sweep) begin
      // The receiver holds off for a long stretch while these go in, so the
      // output register fills and the unit has to stall its input.
      hold_requests <= hold_requests + 1;
      // Lengths around the length-field spill, the block boundary and the
      // maximum length.
      send_message(spdm_pkg::LEN_POS - 1);
      send_message(spdm_pkg::LEN_POS);
      send_message(spdm_pkg::BLOCK_BYTES - 1);
      send_message(spdm_pkg::BLOCK_BYTES);
      send_message(spdm_pkg::MAX_LEN);
      send_message(spdm_pkg::MAX_LEN + 2);
    end
    while (words_sent < target) begin
      if (msg_index == pause_after) wait_drained();
      send_message(pick_length());
      msg_index++;
    end
  endtask

  // Result side: checks each accepted digest against the oldest prediction
  // and drives out_stall, either randomly or for a requested long hold.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digests_pending.size() == 0) begin
        flag_error($sformatf("digest %h_%h with none expected",
                             out_digest_high, out_digest_low));
      end else begin
        oldest_digest = digests_pending.pop_front();
        if (out_digest_low !== oldest_digest.low)
          flag_error($sformatf("digest_low %h, expected %h",
                               out_digest_low, oldest_digest.low));
        if (out_digest_high !== oldest_digest.high)
          flag_error($sformatf("digest_high %h, expected %h",
                               out_digest_high, oldest_digest.high));
      end
    end
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    foreach (block_buf[i]) block_buf[i] = '0;
    chain_word[0] = '0;
    chain_word[1] = '0;
    send_idle_pct = 26;
    recv_idle_pct <= 56;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words run on the reset configuration.
    foreach (DIRECTED_WORDS[i]) offer_word(DIRECTED_WORDS[i].cmd, DIRECTED_WORDS[i].data);

    // Random traffic in three idling modes, each under its own settings.
    run_phase(26, 56, '1, '1, '1, 1'b1, -1);
    run_phase(56, 26, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 1'b0, 4);
    run_phase(0, 0, '0, {$urandom, $urandom}, '1, 1'b0, -1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && digests_pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
